// ----- rtl/afc_pkg.sv -----
// shared constants, types and functions of the affine transform composer
package afc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TRIG_STEPS_DEF = 20;
  localparam int ANG_BITS = 28;
  localparam int ATAN_ENTRIES = 30;
  localparam int XW = 34;
  localparam int ZAW = 38;
  localparam logic signed [XW-1:0] CORDIC_K30 = 34'sd652032874;

  localparam logic [2:0] MODE_IDENT     = 3'd0;
  localparam logic [2:0] MODE_TRANSLATE = 3'd1;
  localparam logic [2:0] MODE_SCALE     = 3'd2;
  localparam logic [2:0] MODE_ROTATE    = 3'd3;
  localparam logic [2:0] MODE_SKEW_X    = 3'd4;
  localparam logic [2:0] MODE_SKEW_Y    = 3'd5;
  localparam logic [2:0] MODE_MATRIX    = 3'd6;
  localparam logic [2:0] MODE_APPLY     = 3'd7;

  typedef struct packed {
    logic                 done;
    logic signed [31:0]   cos_q;
    logic signed [31:0]   sin_q;
    logic signed [XW-1:0] cos30;
    logic signed [XW-1:0] sin30;
  } trig_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh000000007fffffff) begin
      return 32'sh7fffffff;
    end else if (v < 64'shffffffff80000000) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = -(64'(v));
    return sat32(w);
  endfunction

  // arctangent of 2^-i in degrees, Q28
  function automatic logic signed [ZAW-1:0] atan_deg28(input logic [4:0] i);
    case (i)
      5'd0:  return 38'sd12079595520;
      5'd1:  return 38'sd7131001626;
      5'd2:  return 38'sd3767825416;
      5'd3:  return 38'sd1912607013;
      5'd4:  return 38'sd960014950;
      5'd5:  return 38'sd480475470;
      5'd6:  return 38'sd240296363;
      5'd7:  return 38'sd120155514;
      5'd8:  return 38'sd60078674;
      5'd9:  return 38'sd30039451;
      5'd10: return 38'sd15019740;
      5'd11: return 38'sd7509872;
      5'd12: return 38'sd3754936;
      5'd13: return 38'sd1877468;
      5'd14: return 38'sd938734;
      5'd15: return 38'sd469367;
      5'd16: return 38'sd234684;
      5'd17: return 38'sd117342;
      5'd18: return 38'sd58671;
      5'd19: return 38'sd29335;
      5'd20: return 38'sd14668;
      5'd21: return 38'sd7334;
      5'd22: return 38'sd3667;
      5'd23: return 38'sd1833;
      5'd24: return 38'sd917;
      5'd25: return 38'sd458;
      5'd26: return 38'sd229;
      5'd27: return 38'sd115;
      5'd28: return 38'sd57;
      5'd29: return 38'sd29;
      default: return '0;
    endcase
  endfunction

endpackage

// ----- rtl/afc_cmd_if.sv -----
// command channel interface
interface afc_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [2:0]        arg_count;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [31:0] op_c;
  logic signed [31:0] op_d;
  logic signed [31:0] op_e;
  logic signed [31:0] op_f;

  modport source (output valid, mode, arg_count, op_a, op_b, op_c, op_d, op_e, op_f,
                  input ready);
  modport sink (input valid, mode, arg_count, op_a, op_b, op_c, op_d, op_e, op_f,
                output ready);
endinterface

// ----- rtl/afc_pt_if.sv -----
// point result channel interface
interface afc_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;

  modport source (output valid, x_out, y_out, input ready);
  modport sink (input valid, x_out, y_out, output ready);
endinterface

// ----- rtl/affine_transform_composer.sv -----
// top level: svg style 2d affine matrix composer with point transform
// one command at a time; cmd.ready is high only while idle, identity needs no multiplier work
// each matrix product runs 12 serial products on one multiplier
// apply runs 4 products; rotate adds a cordic run,
// skew adds that plus a division; rotate about a center runs three matrix products
// reset loads the identity matrix and empties the result register
module affine_transform_composer #(
  parameter int FRAC_BITS  = afc_pkg::FRAC_BITS_DEF,
  parameter int TRIG_STEPS = afc_pkg::TRIG_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  afc_cmd_if.sink    cmd,
  afc_pt_if.source   pt
);

  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = PW + 2;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRIG = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_NEXT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] PH_PRE  = 2'd0;
  localparam logic [1:0] PH_ROT  = 2'd1;
  localparam logic [1:0] PH_POST = 2'd2;

  logic [2:0]          state;
  logic [1:0]          phase;
  logic [2:0]          mode_r;
  logic [2:0]          k;
  logic                t;
  logic                issued;
  logic                trig_go;
  logic                div_go;
  logic                out_valid;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] total;
  logic signed [31:0]  coef [6];
  logic signed [31:0]  newm [6];
  logic signed [31:0]  p [6];
  logic signed [31:0]  cx;
  logic signed [31:0]  cy;
  logic signed [31:0]  ang;
  logic signed [31:0]  trans;

  logic                mul_start;
  logic                mul_done;
  logic signed [31:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [PW-1:0] mul_prod;
  afc_pkg::trig_res_t  trig_res;
  logic                div_done;
  logic signed [31:0]  tan_q;

  assign cmd.ready = (state == S_IDLE);
  assign pt.valid  = out_valid;

  // term t of coefficient k: old m[k%2 + 2t] times operand p[2(k/2) + t]
  assign mul_start = (state == S_MUL) && !issued;
  assign mul_a     = coef[{1'b0, t, k[0]}];
  assign mul_b     = p[{k[2:1], t}];
  assign trans     = k[0] ? coef[5] : coef[4];
  assign total     = sum + SW'(mul_prod) + (k[2] ? SW'(trans) : SW'(0));

  afc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  afc_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS)) u_trig (
    .clk   (clk),
    .rst   (rst),
    .start (trig_go),
    .deg   (ang),
    .res   (trig_res)
  );

  afc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (trig_res.sin30),
    .den   (trig_res.cos30),
    .done  (div_done),
    .quo   (tan_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_POST;
      mode_r    <= afc_pkg::MODE_IDENT;
      k         <= '0;
      t         <= 1'b0;
      issued    <= 1'b0;
      trig_go   <= 1'b0;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
      coef[0]   <= ONE;
      coef[1]   <= '0;
      coef[2]   <= '0;
      coef[3]   <= ONE;
      coef[4]   <= '0;
      coef[5]   <= '0;
    end else begin
      if (trig_go) begin
        trig_go <= 1'b0;
      end
      if (div_go) begin
        div_go <= 1'b0;
      end
      if (out_valid && pt.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            mode_r <= cmd.mode;
            k      <= '0;
            t      <= 1'b0;
            issued <= 1'b0;
            case (cmd.mode)
              afc_pkg::MODE_IDENT: begin
                coef[0] <= ONE;
                coef[1] <= '0;
                coef[2] <= '0;
                coef[3] <= ONE;
                coef[4] <= '0;
                coef[5] <= '0;
              end
              afc_pkg::MODE_TRANSLATE: begin
                if (cmd.arg_count == 3'd1 || cmd.arg_count == 3'd2) begin
                  p[0]  <= ONE;
                  p[1]  <= '0;
                  p[2]  <= '0;
                  p[3]  <= ONE;
                  p[4]  <= cmd.op_a;
                  p[5]  <= (cmd.arg_count == 3'd2) ? cmd.op_b : 32'sd0;
                  state <= S_MUL;
                end
              end
              afc_pkg::MODE_SCALE: begin
                if (cmd.arg_count == 3'd1 || cmd.arg_count == 3'd2) begin
                  p[0]  <= cmd.op_a;
                  p[1]  <= '0;
                  p[2]  <= '0;
                  p[3]  <= (cmd.arg_count == 3'd2) ? cmd.op_b : cmd.op_a;
                  p[4]  <= '0;
                  p[5]  <= '0;
                  state <= S_MUL;
                end
              end
              afc_pkg::MODE_ROTATE: begin
                if (cmd.arg_count == 3'd1) begin
                  ang     <= cmd.op_a;
                  phase   <= PH_POST;
                  trig_go <= 1'b1;
                  state   <= S_TRIG;
                end else if (cmd.arg_count == 3'd3) begin
                  ang   <= cmd.op_a;
                  cx    <= cmd.op_b;
                  cy    <= cmd.op_c;
                  p[0]  <= ONE;
                  p[1]  <= '0;
                  p[2]  <= '0;
                  p[3]  <= ONE;
                  p[4]  <= cmd.op_b;
                  p[5]  <= cmd.op_c;
                  phase <= PH_PRE;
                  state <= S_MUL;
                end
              end
              afc_pkg::MODE_SKEW_X, afc_pkg::MODE_SKEW_Y: begin
                if (cmd.arg_count == 3'd1) begin
                  ang     <= cmd.op_a;
                  trig_go <= 1'b1;
                  state   <= S_TRIG;
                end
              end
              afc_pkg::MODE_MATRIX: begin
                if (cmd.arg_count == 3'd6) begin
                  p[0]  <= cmd.op_a;
                  p[1]  <= cmd.op_b;
                  p[2]  <= cmd.op_c;
                  p[3]  <= cmd.op_d;
                  p[4]  <= cmd.op_e;
                  p[5]  <= cmd.op_f;
                  state <= S_MUL;
                end
              end
              afc_pkg::MODE_APPLY: begin
                p[4]  <= cmd.op_a;
                p[5]  <= cmd.op_b;
                k     <= 3'd4;
                state <= S_MUL;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_TRIG: begin
          if (trig_res.done) begin
            if (mode_r == afc_pkg::MODE_ROTATE) begin
              p[0]  <= trig_res.cos_q;
              p[1]  <= trig_res.sin_q;
              p[2]  <= afc_pkg::neg_sat(trig_res.sin_q);
              p[3]  <= trig_res.cos_q;
              p[4]  <= '0;
              p[5]  <= '0;
              k     <= '0;
              state <= S_MUL;
            end else begin
              div_go <= 1'b1;
              state  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            p[0]  <= ONE;
            p[1]  <= (mode_r == afc_pkg::MODE_SKEW_Y) ? tan_q : 32'sd0;
            p[2]  <= (mode_r == afc_pkg::MODE_SKEW_X) ? tan_q : 32'sd0;
            p[3]  <= ONE;
            p[4]  <= '0;
            p[5]  <= '0;
            k     <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_start) begin
            issued <= 1'b1;
          end
          if (mul_done) begin
            issued <= 1'b0;
            if (!t) begin
              sum <= SW'(mul_prod);
              t   <= 1'b1;
            end else begin
              newm[k] <= afc_pkg::sat32(64'(total));
              t       <= 1'b0;
              if (k == 3'd5) begin
                state <= S_NEXT;
              end else begin
                k <= k + 3'd1;
              end
            end
          end
        end
        S_NEXT: begin
          if (mode_r == afc_pkg::MODE_APPLY) begin
            state <= S_OUT;
          end else begin
            coef[0] <= newm[0];
            coef[1] <= newm[1];
            coef[2] <= newm[2];
            coef[3] <= newm[3];
            coef[4] <= newm[4];
            coef[5] <= newm[5];
            if (mode_r == afc_pkg::MODE_ROTATE && phase == PH_PRE) begin
              phase   <= PH_ROT;
              trig_go <= 1'b1;
              state   <= S_TRIG;
            end else if (mode_r == afc_pkg::MODE_ROTATE && phase == PH_ROT) begin
              p[0]  <= ONE;
              p[1]  <= '0;
              p[2]  <= '0;
              p[3]  <= ONE;
              p[4]  <= afc_pkg::neg_sat(cx);
              p[5]  <= afc_pkg::neg_sat(cy);
              k     <= '0;
              phase <= PH_POST;
              state <= S_MUL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || pt.ready) begin
            out_valid <= 1'b1;
            pt.x_out  <= newm[4];
            pt.y_out  <= newm[5];
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/afc_mul.sv -----
// bit-serial signed 32x32 multiplier with round half up to the fixed point format
module afc_mul #(
  parameter int FRAC_BITS = afc_pkg::FRAC_BITS_DEF,
  localparam int PW = 64 - FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [31:0]   a,
  input  logic signed [31:0]   b,
  output logic                 done,
  output logic signed [PW-1:0] prod
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RUN  = 2'd1;
  localparam logic [1:0] M_OUT  = 2'd2;
  localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

  logic [1:0]         state;
  logic [4:0]         cnt;
  logic signed [63:0] mc;
  logic signed [63:0] acc;
  logic signed [63:0] addend;
  logic signed [63:0] rnd;
  logic [31:0]        mb;

  // the sign bit of the multiplier carries negative weight
  always_comb begin
    if (!mb[0]) begin
      addend = '0;
    end else if (cnt == 5'd31) begin
      addend = -mc;
    end else begin
      addend = mc;
    end
  end

  assign rnd  = acc + RND;
  assign prod = PW'(rnd >>> FRAC_BITS);
  assign done = (state == M_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        M_IDLE: begin
          if (start) begin
            state <= M_RUN;
            cnt   <= '0;
            mc    <= 64'(a);
            mb    <= b;
            acc   <= '0;
          end
        end
        M_RUN: begin
          acc <= acc + addend;
          mc  <= mc <<< 1;
          mb  <= mb >> 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= M_OUT;
          end
        end
        M_OUT: begin
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/afc_trig.sv -----
// angle reduction and iterative cordic giving cosine and sine of an angle in degrees
module afc_trig #(
  parameter int FRAC_BITS  = afc_pkg::FRAC_BITS_DEF,
  parameter int TRIG_STEPS = afc_pkg::TRIG_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  deg,
  output afc_pkg::trig_res_t  res
);

  localparam int ZW   = 32 + afc_pkg::ANG_BITS - FRAC_BITS;
  localparam int MODS = ZW - 35;
  localparam int JW   = $clog2(MODS + 1);
  localparam logic [36:0] FULL   = 37'd360 << afc_pkg::ANG_BITS;
  localparam logic [36:0] HALF   = 37'd180 << afc_pkg::ANG_BITS;
  localparam logic [36:0] QUART  = 37'd90 << afc_pkg::ANG_BITS;
  localparam logic [36:0] QUART3 = 37'd270 << afc_pkg::ANG_BITS;
  localparam logic signed [63:0] QRND = 64'sd1 <<< (29 - FRAC_BITS);

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_MOD  = 3'd1;
  localparam logic [2:0] T_FIX  = 3'd2;
  localparam logic [2:0] T_FOLD = 3'd3;
  localparam logic [2:0] T_ROT  = 3'd4;
  localparam logic [2:0] T_FLIP = 3'd5;
  localparam logic [2:0] T_OUT  = 3'd6;

  logic [2:0]                        state;
  logic                              neg;
  logic                              flip;
  logic [JW-1:0]                     j;
  logic [4:0]                        i;
  logic [ZW:0]                       r;
  logic [ZW:0]                       sub;
  logic [36:0]                       rz;
  logic signed [ZW-1:0]              zext;
  logic signed [afc_pkg::XW-1:0]     x;
  logic signed [afc_pkg::XW-1:0]     y;
  logic signed [afc_pkg::XW-1:0]     dx;
  logic signed [afc_pkg::XW-1:0]     dy;
  logic signed [afc_pkg::ZAW-1:0]    z;
  logic signed [afc_pkg::ZAW-1:0]    at;
  logic signed [63:0]                xw;
  logic signed [63:0]                yw;

  assign zext = ZW'(deg) <<< (afc_pkg::ANG_BITS - FRAC_BITS);
  assign sub  = (ZW + 1)'(FULL) << j;
  assign rz   = r[36:0];
  assign dx   = y >>> i;
  assign dy   = x >>> i;
  assign at   = afc_pkg::atan_deg28(i);

  always_comb begin
    xw = 64'(x) + QRND;
    yw = 64'(y) + QRND;
    res.done  = (state == T_OUT);
    res.cos30 = x;
    res.sin30 = y;
    res.cos_q = afc_pkg::sat32(xw >>> (30 - FRAC_BITS));
    res.sin_q = afc_pkg::sat32(yw >>> (30 - FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      j     <= '0;
      i     <= '0;
    end else begin
      case (state)
        T_IDLE: begin
          if (start) begin
            neg   <= zext[ZW-1];
            r     <= {1'b0, (zext[ZW-1] ? -zext : zext)};
            j     <= JW'(MODS - 1);
            state <= T_MOD;
          end
        end
        // remainder by 360 degrees, one shifted subtract per cycle
        T_MOD: begin
          if (r >= sub) begin
            r <= r - sub;
          end
          if (j == '0) begin
            state <= T_FIX;
          end else begin
            j <= j - JW'(1);
          end
        end
        T_FIX: begin
          if (neg && (r != '0)) begin
            r <= (ZW + 1)'(FULL) - r;
          end
          state <= T_FOLD;
        end
        // into (-180,180], then into [-90,90]
        T_FOLD: begin
          if (rz <= QUART) begin
            z    <= afc_pkg::ZAW'(rz);
            flip <= 1'b0;
          end else if (rz < QUART3) begin
            z    <= afc_pkg::ZAW'(rz) - afc_pkg::ZAW'(HALF);
            flip <= 1'b1;
          end else begin
            z    <= afc_pkg::ZAW'(rz) - afc_pkg::ZAW'(FULL);
            flip <= 1'b0;
          end
          x     <= afc_pkg::CORDIC_K30;
          y     <= '0;
          i     <= '0;
          state <= T_ROT;
        end
        T_ROT: begin
          if (!z[afc_pkg::ZAW-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at;
          end
          if (i == 5'(TRIG_STEPS - 1)) begin
            state <= T_FLIP;
          end else begin
            i <= i + 5'd1;
          end
        end
        T_FLIP: begin
          if (flip) begin
            x <= -x;
            y <= -y;
          end
          state <= T_OUT;
        end
        T_OUT: begin
          state <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/afc_div.sv -----
// radix-2 restoring divider for the tangent, quotient truncated and saturated
module afc_div #(
  parameter int FRAC_BITS = afc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [afc_pkg::XW-1:0] num,
  input  logic signed [afc_pkg::XW-1:0] den,
  output logic                          done,
  output logic signed [31:0]            quo
);

  localparam int XW = afc_pkg::XW;
  localparam int NW = XW + FRAC_BITS;
  localparam int CW = $clog2(NW);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;
  localparam logic [1:0] D_OUT  = 2'd3;

  logic [1:0]        state;
  logic [CW-1:0]     cnt;
  logic              neg;
  logic [XW:0]       rem;
  logic [XW:0]       rsh;
  logic              ge;
  logic [NW-1:0]     dvd;
  logic [XW-1:0]     dmag;
  logic [XW-1:0]     nmag;
  logic signed [31:0] res;

  assign nmag = num[XW-1] ? XW'(-num) : XW'(num);
  assign rsh  = {rem[XW-1:0], dvd[NW-1]};
  assign ge   = (rsh >= {1'b0, dmag});
  assign done = (state == D_OUT);
  assign quo  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            if (den == '0) begin
              res   <= num[XW-1] ? 32'sh80000000 : 32'sh7fffffff;
              state <= D_OUT;
            end else begin
              neg   <= num[XW-1] ^ den[XW-1];
              dmag  <= den[XW-1] ? XW'(-den) : XW'(den);
              dvd   <= {nmag, FRAC_BITS'(0)};
              rem   <= '0;
              cnt   <= '0;
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem <= ge ? (rsh - {1'b0, dmag}) : rsh;
          dvd <= {dvd[NW-2:0], ge};
          if (cnt == CW'(NW - 1)) begin
            state <= D_FIN;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        D_FIN: begin
          if (neg) begin
            if (dvd > (NW'(1) << 31)) begin
              res <= 32'sh80000000;
            end else begin
              res <= -(dvd[31:0]);
            end
          end else begin
            if (dvd > ((NW'(1) << 31) - NW'(1))) begin
              res <= 32'sh7fffffff;
            end else begin
              res <= dvd[31:0];
            end
          end
          state <= D_OUT;
        end
        D_OUT: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule
